>>> hw/rtl/polyphonic_wavetable_mixer_assert.svh
// assertion macros for the polyphonic wavetable mixer
`ifndef POLYPHONIC_WAVETABLE_MIXER_ASSERT_SVH
`define POLYPHONIC_WAVETABLE_MIXER_ASSERT_SVH

// same-cycle implication
`define PWTM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PWTM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/pwtm_pkg.sv
// shared constants and request codes of the wavetable mixer
`default_nettype none

package pwtm_pkg;

	// sizes (table size is a power of two)
	localparam int MAX_NOTES  = 8;
	localparam int TABLE_SIZE = 256;
	localparam int LOOP_LEN   = 16384;

	localparam int NOTE_IDX_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
	localparam int TBL_W      = $clog2(TABLE_SIZE);
	localparam int POS_W      = $clog2(LOOP_LEN);

	// field widths
	localparam int REQ_W      = 3;
	localparam int SLOT_W     = 3;
	localparam int FREQ_W     = 13;
	localparam int VOL_W      = 9;
	localparam int TIDX_W     = 8;
	localparam int WORD_W     = 16;
	localparam int SAMPLE_W   = 16;
	localparam int PPH_W      = 16;

	// fixed point
	localparam int INC_W      = 24;
	localparam int FRAC_W     = 16;
	localparam int VOL_FRAC_W = 8;

	// shared multiplier
	localparam int OPA_W      = INC_W;
	localparam int OPB_W      = 16;
	localparam int PROD_W     = OPA_W + OPB_W;

	localparam logic [PPH_W-1:0] PPH_RESET = 16'd1049;

	typedef logic [REQ_W-1:0] req_type_t;

	localparam req_type_t REQ_TICK  = 3'd0;
	localparam req_type_t REQ_ADD   = 3'd1;
	localparam req_type_t REQ_DEL   = 3'd2;
	localparam req_type_t REQ_VOL   = 3'd3;
	localparam req_type_t REQ_CLEAR = 3'd4;
	localparam req_type_t REQ_TABLE = 3'd5;

endpackage

`default_nettype wire

>>> hw/rtl/pwtm_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module pwtm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire logic [WIDTH-1:0]           wr_data,
	input  wire logic                       rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic      [WIDTH-1:0]           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/polyphonic_wavetable_mixer.sv
// top level of the polyphonic wavetable mixer: note table, sequencer, shared multiplier
//
//  channel   signals                       direction  payload
//  request   req_valid / req_ready         in         req_type slot note_frequency
//                                                     note_volume table_index table_value
//  response  rsp_valid / rsp_ready         out        sample slot_out ok
//  config    cfg_wr_en / cfg_wr_data       in         phase_per_hz
//
// non-tick requests are answered from the response register; the response is valid on the next cycle.
// a tick walks the note slots with one 24x16 multiplier and the table ram:
// a free slot is skipped in ST_INC, an active slot passes ST_INC, ST_IDX, ST_RD,
// ST_VOL and ST_ACC, and the tick ends in ST_DONE.
// reset frees every slot, makes the wave table read as zero and loads phase 1049.
// a stalled response holds the finished tick; requests are taken only when the
// sequencer is idle and the response register is free or draining.
`default_nettype none

`include "polyphonic_wavetable_mixer_assert.svh"

module polyphonic_wavetable_mixer (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [pwtm_pkg::PPH_W-1:0]      cfg_wr_data,
	input  wire logic                            req_valid,
	output logic                                 req_ready,
	input  wire logic [pwtm_pkg::REQ_W-1:0]      req_type,
	input  wire logic [pwtm_pkg::SLOT_W-1:0]     slot,
	input  wire logic [pwtm_pkg::FREQ_W-1:0]     note_frequency,
	input  wire logic [pwtm_pkg::VOL_W-1:0]      note_volume,
	input  wire logic [pwtm_pkg::TIDX_W-1:0]     table_index,
	input  wire logic [pwtm_pkg::WORD_W-1:0]     table_value,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_ready,
	output logic      [pwtm_pkg::SAMPLE_W-1:0]   sample,
	output logic      [pwtm_pkg::SLOT_W-1:0]     slot_out,
	output logic                                 ok
);

	import pwtm_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INC  = 3'd1;
	localparam logic [2:0] ST_IDX  = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_VOL  = 3'd4;
	localparam logic [2:0] ST_ACC  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	localparam logic [NOTE_IDX_W-1:0] LAST_NOTE = NOTE_IDX_W'(MAX_NOTES - 1);
	localparam logic [POS_W-1:0]      LAST_POS  = POS_W'(LOOP_LEN - 1);

	logic [2:0]              state_q;
	logic [NOTE_IDX_W-1:0]   cnt_q;
	logic [PPH_W-1:0]        pph_q;
	logic [FREQ_W-1:0]       note_freq_q [MAX_NOTES];
	logic [VOL_W-1:0]        note_vol_q  [MAX_NOTES];
	logic [POS_W-1:0]        pos_q;
	logic [PROD_W-1:0]       prod_q;
	logic [SAMPLE_W-1:0]     sum_q;
	logic [TABLE_SIZE-1:0]   tbl_valid_q;
	logic                    tbl_hit_q;
	logic                    rsp_valid_q;
	logic [SAMPLE_W-1:0]     rsp_sample_q;
	logic [SLOT_W-1:0]       rsp_slot_q;
	logic                    rsp_ok_q;

	logic                    req_fire;
	logic                    rsp_free;
	logic                    is_tick;
	logic                    done_load;
	logic                    last_note;
	logic [FREQ_W-1:0]       cur_freq;
	logic [VOL_W-1:0]        cur_vol;
	logic                    slot_ok;
	logic [NOTE_IDX_W-1:0]   slot_idx;
	logic                    tidx_ok;
	logic [TBL_W-1:0]        tidx_addr;
	logic                    free_found;
	logic [NOTE_IDX_W-1:0]   free_idx;
	logic                    add_ok;
	logic [SLOT_W-1:0]       imm_slot;
	logic                    imm_ok;
	logic                    tbl_we;
	logic [TBL_W-1:0]        rd_addr;
	logic [WORD_W-1:0]       rd_data;
	logic [WORD_W-1:0]       tbl_word;
	logic [INC_W-1:0]        inc_sat;
	logic [OPA_W-1:0]        op_a;
	logic [OPB_W-1:0]        op_b;
	logic [PROD_W-1:0]       mul_out;
	logic [POS_W-1:0]        next_pos;

	// handshake
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE) && rsp_free;
	assign req_fire  = req_valid && req_ready;
	assign is_tick   = (req_type == REQ_TICK);
	assign done_load = (state_q == ST_DONE) && rsp_free;

	assign rsp_valid = rsp_valid_q;
	assign sample    = rsp_sample_q;
	assign slot_out  = rsp_slot_q;
	assign ok        = rsp_ok_q;

	// request field decode
	assign slot_ok   = int'(slot) < MAX_NOTES;
	assign slot_idx  = NOTE_IDX_W'(slot);
	assign tidx_ok   = int'(table_index) < TABLE_SIZE;
	assign tidx_addr = TBL_W'(table_index);
	assign tbl_we    = req_fire && (req_type == REQ_TABLE) && tidx_ok;

	// first free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = 0; i < MAX_NOTES; i++) begin
			if (!free_found && (note_freq_q[i] == '0)) begin
				free_found = 1'b1;
				free_idx   = NOTE_IDX_W'(i);
			end
		end
	end

	assign add_ok = (note_frequency != '0) && free_found;

	// response fields of the note and table requests
	always_comb begin
		imm_slot = '0;
		imm_ok   = 1'b0;
		unique case (req_type)
			REQ_ADD: begin
				imm_ok   = add_ok;
				imm_slot = add_ok ? SLOT_W'(free_idx) : '0;
			end
			REQ_DEL, REQ_VOL: begin
				imm_ok = slot_ok;
			end
			REQ_CLEAR: begin
				imm_ok = 1'b1;
			end
			REQ_TABLE: begin
				imm_ok = tidx_ok;
			end
			default: begin
				imm_ok = 1'b0;
			end
		endcase
	end

	// phase per hertz register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pph_q <= PPH_RESET;
		end else if (cfg_wr_en) begin
			pph_q <= cfg_wr_data;
		end
	end

	// note table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_NOTES; i++) begin
				note_freq_q[i] <= '0;
				note_vol_q[i]  <= '0;
			end
		end else if (req_fire) begin
			unique case (req_type)
				REQ_ADD: begin
					if (add_ok) begin
						note_freq_q[free_idx] <= note_frequency;
						note_vol_q[free_idx]  <= note_volume;
					end
				end
				REQ_DEL: begin
					if (slot_ok) begin
						note_freq_q[slot_idx] <= '0;
						note_vol_q[slot_idx]  <= '0;
					end
				end
				REQ_VOL: begin
					if (slot_ok) begin
						note_vol_q[slot_idx] <= note_volume;
					end
				end
				REQ_CLEAR: begin
					for (int i = 0; i < MAX_NOTES; i++) begin
						note_freq_q[i] <= '0;
						note_vol_q[i]  <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// table entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_valid_q <= '0;
		end else if (tbl_we) begin
			tbl_valid_q[tidx_addr] <= 1'b1;
		end
	end

	pwtm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_SIZE)
	) u_table (
		.clk     (clk),
		.wr_en   (tbl_we),
		.wr_addr (tidx_addr),
		.wr_data (table_value),
		.rd_en   (state_q == ST_RD),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// current slot and derived operands
	assign cur_freq  = note_freq_q[cnt_q];
	assign cur_vol   = note_vol_q[cnt_q];
	assign last_note = (cnt_q == LAST_NOTE);
	assign inc_sat   = (prod_q[PROD_W-1:INC_W] != '0) ? '1 : prod_q[INC_W-1:0];
	assign rd_addr   = prod_q[FRAC_W +: TBL_W];
	assign tbl_word  = tbl_hit_q ? rd_data : '0;
	assign next_pos  = (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;

	// shared multiplier operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			ST_INC: begin
				op_a = OPA_W'(cur_freq);
				op_b = OPB_W'(pph_q);
			end
			ST_IDX: begin
				op_a = inc_sat;
				op_b = OPB_W'(pos_q);
			end
			ST_VOL: begin
				op_a = OPA_W'(tbl_word);
				op_b = OPB_W'(cur_vol);
			end
			default: begin
			end
		endcase
	end

	assign mul_out = PROD_W'(op_a) * PROD_W'(op_b);

	// tick sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire && is_tick) begin
						state_q <= ST_INC;
						cnt_q   <= '0;
					end
				end
				ST_INC: begin
					if (cur_freq == '0) begin
						if (last_note) begin
							state_q <= ST_DONE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end else begin
						state_q <= ST_IDX;
					end
				end
				ST_IDX: begin
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_VOL;
				end
				ST_VOL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (last_note) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_INC;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
						pos_q   <= next_pos;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// mix datapath
	always_ff @(posedge clk) begin
		if ((state_q == ST_INC) || (state_q == ST_IDX) || (state_q == ST_VOL)) begin
			prod_q <= mul_out;
		end
		if (state_q == ST_RD) begin
			tbl_hit_q <= tbl_valid_q[rd_addr];
		end
		if (req_fire && is_tick) begin
			sum_q <= '0;
		end else if (state_q == ST_ACC) begin
			sum_q <= sum_q + prod_q[VOL_FRAC_W +: SAMPLE_W];
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((req_fire && !is_tick) || done_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire && !is_tick) begin
			rsp_sample_q <= '0;
			rsp_slot_q   <= imm_slot;
			rsp_ok_q     <= imm_ok;
		end else if (done_load) begin
			rsp_sample_q <= sum_q;
			rsp_slot_q   <= '0;
			rsp_ok_q     <= 1'b1;
		end
	end

	// checks
	`PWTM_ASSERT_NXT(a_tick_busy, clk, arst_n, req_fire && is_tick, !req_ready, "tick accepted while ready stays high")
	`PWTM_ASSERT_NXT(a_cmd_rsp, clk, arst_n, req_fire && !is_tick, rsp_valid_q && (rsp_sample_q == '0), "non-tick request gave no zero-sample response")
	`PWTM_ASSERT_NXT(a_pos_hold, clk, arst_n, !done_load, $stable(pos_q), "position moved outside tick completion")
	`PWTM_ASSERT_IMP(a_cnt_range, clk, arst_n, state_q != ST_IDLE, cnt_q <= LAST_NOTE, "slot counter out of range")

endmodule

`default_nettype wire
